>>> hw/rtl/blake2b_stream_hash_core_defines.svh
// Assertion macros shared by the checker
`ifndef BLAKE2B_STREAM_HASH_CORE_DEFINES_SVH
`define BLAKE2B_STREAM_HASH_CORE_DEFINES_SVH
// Check a property on every rising clock edge outside reset
`define B2B_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property without a reset qualifier
`define B2B_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> hw/rtl/b2b_pkg.sv
package b2b_pkg;

    localparam int BlockBytes = 128;
    localparam int Rounds     = 12;

    typedef logic [63:0] word_t;

    localparam word_t IV [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
        64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};

    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}};

    // G-function column/diagonal index sets (a, b, c, d)
    localparam logic [3:0] GA [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd3};
    localparam logic [3:0] GB [8] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7, 4'd4};
    localparam logic [3:0] GC [8] = '{4'd8, 4'd9, 4'd10, 4'd11, 4'd10, 4'd11, 4'd8, 4'd9};
    localparam logic [3:0] GD [8] = '{4'd12, 4'd13, 4'd14, 4'd15, 4'd15, 4'd12, 4'd13, 4'd14};

    localparam logic [1:0] RegDigestLength = 2'd0;
    localparam logic [1:0] RegKeyLength    = 2'd1;

    // Commands from controller to datapath
    typedef struct packed {
        logic init;       // reload chain value from IV and parameters
        logic load;       // write input byte into buffer
        logic pad;        // write zero at fill position
        logic start;      // set up working vector, add to counter
        logic final_blk;  // final flag for start
        logic step;       // one G half-step
        logic finish;     // fold working vector into chain value
    } b2b_cmd_t;

    typedef struct packed {
        logic [7:0] fill;     // bytes held, 0..128
        logic       g_done;   // last half-step of last round
    } b2b_sts_t;

    function automatic logic [6:0] eff_digest(input logic [6:0] d);
        logic [6:0] r;
        r = d;
        if (d == 7'd0) r = 7'd1;
        if (d > 7'd64) r = 7'd64;
        return r;
    endfunction

endpackage

>>> hw/rtl/b2b_stream_if.sv
interface b2b_stream_if #(
    parameter int W = 10
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/blake2b_stream_hash_core.sv
// Compression: a byte accepted while a full block is held loads only after the block is compressed
// (start, then G half-steps at one per cycle, then fold).
// Finish: zero-pad the block to 128 bytes, compress it, then one digest byte per cycle while out_ready is high.
// No input is taken during compression, so long messages are limited by the single G unit.
// Reset: asynchronous active-low; chain value loads IV with default parameters.
module blake2b_stream_hash_core (
    input  logic             clk,
    input  logic             rst_n,
    b2b_stream_if.sink       in_ch,
    b2b_stream_if.source     out_ch,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [6:0]       cfg_wdata
);
    logic [6:0] dlen_reg;
    logic [6:0] klen_reg;
    logic [7:0] in_byte_reg;
    logic [5:0] out_idx;
    logic       out_last;
    logic [7:0] out_byte;
    b2b_pkg::b2b_cmd_t cmd;
    b2b_pkg::b2b_sts_t sts;

    // Hold the byte of an item accepted while a full block waits for compression.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg <= in_ch.payload[7:0];
        end
    end

    // Drop the config write into the register it names.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlen_reg <= 7'd64;
            klen_reg <= 7'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                b2b_pkg::RegDigestLength[0:0]: dlen_reg <= cfg_wdata;
                b2b_pkg::RegKeyLength[0:0]:    klen_reg <= cfg_wdata;
                default:                       dlen_reg <= dlen_reg;
            endcase
        end
    end

    b2b_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .has_byte       (in_ch.payload[8]),
        .end_of_message (in_ch.payload[9]),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_last       (out_last),
        .out_idx        (out_idx),
        .digest_length  (dlen_reg),
        .cfg_we         (cfg_we),
        .sts            (sts),
        .cmd            (cmd)
    );

    // Load uses the live byte in idle, the held byte after a compression.
    b2b_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_byte       (in_ch.ready ? in_ch.payload[7:0] : in_byte_reg),
        .digest_length (cfg_we && cfg_index == b2b_pkg::RegDigestLength[0:0] ? cfg_wdata : dlen_reg),
        .key_length    (cfg_we && cfg_index == b2b_pkg::RegKeyLength[0:0] ? cfg_wdata : klen_reg),
        .out_idx       (out_idx),
        .sts           (sts),
        .out_byte      (out_byte)
    );

    assign out_ch.payload = {out_last, out_byte};
endmodule

>>> hw/rtl/b2b_datapath.sv
module b2b_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  b2b_pkg::b2b_cmd_t   cmd,
    input  logic [7:0]          in_byte,
    input  logic [6:0]          digest_length,
    input  logic [6:0]          key_length,
    input  logic [5:0]          out_idx,
    output b2b_pkg::b2b_sts_t   sts,
    output logic [7:0]          out_byte
);
    // Block buffer: 16 words, each byte written in place
    b2b_pkg::word_t msg_reg [16];
    b2b_pkg::word_t h_reg [8];
    b2b_pkg::word_t v_reg [16];
    logic [127:0]   cnt_reg;
    logic [7:0]     fill_reg;
    logic [7:0]     used_reg;  // message bytes in the block, padding excluded
    logic [3:0]     round_reg;
    logic [3:0]     g_reg;     // g index 0..7
    logic           half_reg;  // first or second half of G

    logic [6:0] klen;
    logic [63:0] param;
    logic [3:0] ia, ib, ic, id, sig_i;
    b2b_pkg::word_t m_x, a_n, d_n, c_n, b_n;
    logic [3:0] srow;
    logic [127:0] cnt_sum;

    assign klen  = (key_length > 7'd64) ? 7'd64 : key_length;
    assign param = {32'd0, 8'd1, 8'd1, 1'b0, klen, 1'b0,
                    b2b_pkg::eff_digest(digest_length)};

    assign ia = b2b_pkg::GA[g_reg[2:0]];
    assign ib = b2b_pkg::GB[g_reg[2:0]];
    assign ic = b2b_pkg::GC[g_reg[2:0]];
    assign id = b2b_pkg::GD[g_reg[2:0]];
    assign srow = (round_reg >= 4'd10) ? round_reg - 4'd10 : round_reg;
    assign sig_i = b2b_pkg::SIGMA[srow][{g_reg[2:0], half_reg}];
    assign m_x = msg_reg[sig_i];
    assign cnt_sum = cnt_reg + {120'd0, used_reg};

    always_comb
    begin
        a_n = v_reg[ia] + v_reg[ib] + m_x;
        d_n = v_reg[id] ^ a_n;
        d_n = half_reg ? {d_n[15:0], d_n[63:16]} : {d_n[31:0], d_n[63:32]};
        c_n = v_reg[ic] + d_n;
        b_n = v_reg[ib] ^ c_n;
        b_n = half_reg ? {b_n[62:0], b_n[63]} : {b_n[23:0], b_n[63:24]};
    end

    assign sts.fill   = fill_reg;
    assign sts.g_done = half_reg && (g_reg == 4'd7) && (round_reg == 4'(b2b_pkg::Rounds - 1));
    assign out_byte   = h_reg[out_idx[5:3]][8*out_idx[2:0] +: 8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= 8'd0;
            used_reg  <= 8'd0;
            cnt_reg   <= 128'd0;
            round_reg <= 4'd0;
            g_reg     <= 4'd0;
            half_reg  <= 1'b0;
            h_reg[0]  <= b2b_pkg::IV[0] ^ 64'h0000_0000_0101_0040;
            for (int i = 1; i < 8; i++)
            begin
                h_reg[i] <= b2b_pkg::IV[i];
            end
        end
        else
        begin
            if (cmd.init)
            begin
                h_reg[0] <= b2b_pkg::IV[0] ^ param;
                for (int i = 1; i < 8; i++)
                begin
                    h_reg[i] <= b2b_pkg::IV[i];
                end
                cnt_reg  <= 128'd0;
            end
            if (cmd.load || cmd.pad)
            begin
                msg_reg[fill_reg[6:3]][8*fill_reg[2:0] +: 8] <= cmd.load ? in_byte : 8'd0;
            end
            // The deferred byte lands at the start of a fresh block
            if (cmd.init || cmd.finish)
            begin
                fill_reg <= (cmd.finish && cmd.load) ? 8'd1 : 8'd0;
                used_reg <= (cmd.finish && cmd.load) ? 8'd1 : 8'd0;
            end
            else
            begin
                if (cmd.load || cmd.pad)
                begin
                    fill_reg <= fill_reg + 8'd1;
                end
                if (cmd.load)
                begin
                    used_reg <= used_reg + 8'd1;
                end
            end
            if (cmd.start)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i]     <= h_reg[i];
                    v_reg[i + 8] <= b2b_pkg::IV[i];
                end
                v_reg[12] <= b2b_pkg::IV[4] ^ cnt_sum[63:0];
                v_reg[13] <= b2b_pkg::IV[5] ^ cnt_sum[127:64];
                v_reg[14] <= cmd.final_blk ? ~b2b_pkg::IV[6] : b2b_pkg::IV[6];
                cnt_reg   <= cnt_sum;
                round_reg <= 4'd0;
                g_reg     <= 4'd0;
                half_reg  <= 1'b0;
            end
            if (cmd.step)
            begin
                v_reg[ia] <= a_n;
                v_reg[ib] <= b_n;
                v_reg[ic] <= c_n;
                v_reg[id] <= d_n;
                half_reg  <= ~half_reg;
                if (half_reg)
                begin
                    g_reg <= (g_reg == 4'd7) ? 4'd0 : g_reg + 4'd1;
                    if (g_reg == 4'd7)
                    begin
                        round_reg <= round_reg + 4'd1;
                    end
                end
            end
            if (cmd.finish)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[i + 8];
                end
            end
        end
    end
endmodule

>>> hw/rtl/b2b_ctrl.sv
module b2b_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              has_byte,
    input  logic              end_of_message,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_last,
    output logic [5:0]        out_idx,
    input  logic [6:0]        digest_length,
    input  logic              cfg_we,
    input  b2b_pkg::b2b_sts_t sts,
    output b2b_pkg::b2b_cmd_t cmd
);
    typedef enum logic [2:0] {S_IDLE, S_PAD, S_COMP, S_FOLD, S_OUT} state_t;
    state_t     state_reg, state_next;
    logic       final_reg, final_next;
    logic       eom_reg, eom_next;
    logic [5:0] idx_reg, idx_next;
    logic [6:0] n_last;
    logic       acc;

    assign n_last   = b2b_pkg::eff_digest(digest_length) - 7'd1;
    assign in_ready = (state_reg == S_IDLE) && !cfg_we;
    assign acc      = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT);
    assign out_idx   = idx_reg;
    assign out_last  = ({1'b0, idx_reg} == n_last);

    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        eom_next   = eom_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.init   = cfg_we;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (has_byte && sts.fill == 8'd128)
                    begin
                        // full block held: compress first, then take byte
                        cmd.start  = 1'b1;
                        final_next = 1'b0;
                        eom_next   = end_of_message;
                        state_next = S_COMP;
                    end
                    else
                    begin
                        cmd.load = has_byte;
                        if (end_of_message)
                        begin
                            state_next = S_PAD;
                        end
                    end
                end
            end
            S_PAD:
            begin
                if (sts.fill == 8'd128)
                begin
                    cmd.start       = 1'b1;
                    cmd.final_blk   = 1'b1;
                    final_next      = 1'b1;
                    state_next      = S_COMP;
                end
                else
                begin
                    cmd.pad = 1'b1;
                end
            end
            S_COMP:
            begin
                cmd.step = 1'b1;
                if (sts.g_done)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.finish = 1'b1;
                idx_next   = 6'd0;
                state_next = final_reg ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 6'd1;
                    if (out_last)
                    begin
                        cmd.init   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_FOLD && !final_reg)
        begin
            // deferred byte of the item that triggered compression
            cmd.load = 1'b1;
            if (eom_reg)
            begin
                state_next = S_PAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            final_reg <= 1'b0;
            eom_reg   <= 1'b0;
            idx_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
            eom_reg   <= eom_next;
            idx_reg   <= idx_next;
        end
    end
endmodule

>>> hw/rtl/b2b_checker.sv
`include "blake2b_stream_hash_core_defines.svh"
module b2b_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [8:0] out_payload
);
    // No input is taken while a digest is being shown.
    `B2B_ASSERT(a_no_overlap, !(out_valid && in_ready), "input ready during digest output")
    // A stalled digest item holds its payload.
    `B2B_ASSERT(a_hold, (out_valid && !out_ready) |=> $stable(out_payload), "payload changed")
    // The last digest byte ends the run.
    `B2B_ASSERT(a_last_ends, (out_valid && out_ready && out_payload[8]) |=> !out_valid,
                "output continued after last")
    `B2B_ASSERT_ALWAYS(a_reset, !rst_n |-> !out_valid, "output valid in reset")
endmodule

bind blake2b_stream_hash_core b2b_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);
